/* rtl/snc_pkg.sv */
// Shared types and codes for the non-preemptive schedule calculator.
// Used by the front end, the record queue, the scheduler back end and the top level.
package snc_pkg;

  localparam int unsigned ARR_W  = 16;
  localparam int unsigned BUR_W  = 16;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned TIME_W = 23;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  // One classified process record as it travels from the front end to the back end.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic             store;
    logic             last;
  } snc_rec_t;

endpackage

/* rtl/snc_front.sv */
// Front end: accepts process records and classifies them as stored, dropped or batch end.
// Depends on snc_pkg.
module snc_front #(
  parameter int unsigned MAX_PROCESSES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [snc_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [snc_pkg::BUR_W-1:0]   in_burst_time,
  input  logic [snc_pkg::PRI_W-1:0]   in_priority_level,
  input  logic                        in_last_process,
  input  logic                        q_full,
  output logic                        q_push,
  output snc_pkg::snc_rec_t           q_rec
);

  localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);

  logic [CW-1:0] cnt_r;
  logic          accept;
  logic          room;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign room    = (cnt_r < CW'(MAX_PROCESSES));

  assign q_rec.arrival = in_arrival_time;
  assign q_rec.burst   = in_burst_time;
  assign q_rec.prio    = in_priority_level;
  assign q_rec.store   = room;
  assign q_rec.last    = in_last_process;

  // A record beyond the batch limit is swallowed unless it closes the batch.
  assign q_push = accept && (room || in_last_process);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      if (in_last_process) begin
        cnt_r <= '0;
      end else if (room) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

endmodule

/* rtl/snc_fifo.sv */
// Short record queue between the front end and the scheduler back end.
// Depends on snc_pkg for the record type.
module snc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  snc_pkg::snc_rec_t wr_rec,
  output logic              full,
  input  logic              pop,
  output snc_pkg::snc_rec_t rd_rec,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  snc_pkg::snc_rec_t slot_r [DEPTH];
  logic [PW-1:0]     wp_r;
  logic [PW-1:0]     rp_r;
  logic [NW-1:0]     num_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (num_r == NW'(DEPTH));
  assign empty   = (num_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      num_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        num_r <= num_r + NW'(1);
      end else if (do_pop && !do_push) begin
        num_r <= num_r - NW'(1);
      end
    end
  end

endmodule

/* rtl/snc_sched.sv */
// Scheduler back end: stores a batch, runs the selection scans and reports per-process times.
// Depends on snc_pkg.
module snc_sched #(
  parameter int unsigned MAX_PROCESSES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [snc_pkg::MODE_W-1:0]   mode,
  input  snc_pkg::snc_rec_t            q_rec,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [snc_pkg::IDX_W-1:0]    out_process_index,
  output logic [snc_pkg::TIME_W-1:0]   out_completion_time,
  output logic [snc_pkg::TIME_W-1:0]   out_turnaround_time,
  output logic [snc_pkg::TIME_W-1:0]   out_waiting_time,
  output logic                         out_last_result
);

  localparam int unsigned AW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TW    = snc_pkg::TIME_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_REP_RD,
    ST_REP_SUB,
    ST_REP_OUT
  } state_t;

  state_t state_r;

  // Record stores, one write and one registered read port each.
  logic [snc_pkg::ARR_W-1:0] arr_mem [DEPTH];
  logic [snc_pkg::BUR_W-1:0] bur_mem [DEPTH];
  logic [snc_pkg::PRI_W-1:0] pri_mem [DEPTH];
  logic [TW-1:0]             fin_mem [DEPTH];
  logic [snc_pkg::ARR_W-1:0] arr_q;
  logic [snc_pkg::BUR_W-1:0] bur_q;
  logic [snc_pkg::PRI_W-1:0] pri_q;
  logic [TW-1:0]             fin_q;

  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             issue_r;
  logic [CW-1:0]             fin_cnt_r;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_idx_r;
  logic [DEPTH-1:0]          done_r;
  logic [TW-1:0]             time_r;
  logic                      found_r;
  logic [AW-1:0]             best_idx_r;
  logic [snc_pkg::ARR_W-1:0] best_arr_r;
  logic [snc_pkg::BUR_W-1:0] best_bur_r;
  logic [snc_pkg::PRI_W-1:0] best_pri_r;
  logic [snc_pkg::ARR_W-1:0] next_arr_r;
  logic [AW-1:0]             rep_r;
  logic [TW-1:0]             tat_r;
  logic                      out_vld_r;
  logic [snc_pkg::IDX_W-1:0] out_idx_r;
  logic [TW-1:0]             out_ct_r;
  logic [TW-1:0]             out_tat_r;
  logic [TW-1:0]             out_wt_r;
  logic                      out_last_r;

  logic                      ld_we;
  logic [AW-1:0]             ld_addr;
  logic [AW-1:0]             rd_addr;
  logic                      fin_we;
  logic [TW-1:0]             fin_data;
  logic                      arrived;
  logic                      better;
  logic                      take;
  logic                      next_upd;
  logic                      rep_last;
  logic                      out_free;

  assign q_pop    = (state_r == ST_LOAD) && !q_empty;
  assign ld_we    = q_pop && q_rec.store;
  assign ld_addr  = cnt_r[AW-1:0];
  assign rd_addr  = (state_r == ST_SCAN) ? issue_r[AW-1:0] : rep_r;
  assign fin_we   = (state_r == ST_PICK) && found_r;
  assign fin_data = time_r + TW'(best_bur_r);

  assign arrived = (TW'(arr_q) <= time_r);

  // The scan runs in index order, so on a full tie the earlier pick stays.
  always_comb begin
    case (mode)
      snc_pkg::MODE_SJF: begin
        better = (bur_q != best_bur_r) ? (bur_q < best_bur_r) : (arr_q < best_arr_r);
      end
      snc_pkg::MODE_PRIO: begin
        better = (pri_q != best_pri_r) ? (pri_q > best_pri_r) : (arr_q < best_arr_r);
      end
      default: begin
        better = (arr_q < best_arr_r);
      end
    endcase
  end

  assign take     = rd_vld_r && !done_r[rd_idx_r] && arrived && (!found_r || better);
  assign next_upd = rd_vld_r && !done_r[rd_idx_r] && !arrived && (arr_q < next_arr_r);
  assign rep_last = ((CW'(rep_r) + CW'(1)) == cnt_r);
  assign out_free = !out_vld_r || out_pop;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      arr_mem[ld_addr] <= q_rec.arrival;
      bur_mem[ld_addr] <= q_rec.burst;
      pri_mem[ld_addr] <= q_rec.prio;
    end
    arr_q <= arr_mem[rd_addr];
    bur_q <= bur_mem[rd_addr];
    pri_q <= pri_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[best_idx_r] <= fin_data;
    end
    fin_q <= fin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      issue_r   <= '0;
      fin_cnt_r <= '0;
      rd_vld_r  <= 1'b0;
      done_r    <= '0;
      time_r    <= '0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
      rep_r     <= '0;
    end else begin
      rd_vld_r <= 1'b0;
      if (out_vld_r && out_pop) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_rec.store) begin
              cnt_r <= cnt_r + CW'(1);
            end
            if (q_rec.last) begin
              done_r     <= '0;
              time_r     <= '0;
              fin_cnt_r  <= '0;
              issue_r    <= '0;
              found_r    <= 1'b0;
              next_arr_r <= '1;
              state_r    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue_r != cnt_r) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= issue_r[AW-1:0];
            issue_r  <= issue_r + CW'(1);
          end else if (!rd_vld_r) begin
            state_r <= ST_PICK;
          end
          if (take) begin
            found_r    <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_arr_r <= arr_q;
            best_bur_r <= bur_q;
            best_pri_r <= pri_q;
          end else if (next_upd) begin
            next_arr_r <= arr_q;
          end
        end
        ST_PICK: begin
          issue_r    <= '0;
          found_r    <= 1'b0;
          next_arr_r <= '1;
          state_r    <= ST_SCAN;
          if (found_r) begin
            done_r[best_idx_r] <= 1'b1;
            time_r             <= fin_data;
            fin_cnt_r          <= fin_cnt_r + CW'(1);
            if ((fin_cnt_r + CW'(1)) == cnt_r) begin
              rep_r   <= '0;
              state_r <= ST_REP_RD;
            end
          end else begin
            // Nothing has arrived yet, so jump to the next arrival.
            time_r <= TW'(next_arr_r);
          end
        end
        ST_REP_RD: begin
          state_r <= ST_REP_SUB;
        end
        ST_REP_SUB: begin
          tat_r   <= fin_q - TW'(arr_q);
          state_r <= ST_REP_OUT;
        end
        ST_REP_OUT: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            out_idx_r  <= snc_pkg::IDX_W'(rep_r);
            out_ct_r   <= fin_q;
            out_tat_r  <= tat_r;
            out_wt_r   <= tat_r - TW'(bur_q);
            out_last_r <= rep_last;
            if (rep_last) begin
              cnt_r   <= '0;
              state_r <= ST_LOAD;
            end else begin
              rep_r   <= rep_r + AW'(1);
              state_r <= ST_REP_RD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_empty           = !out_vld_r;
  assign out_process_index   = out_idx_r;
  assign out_completion_time = out_ct_r;
  assign out_turnaround_time = out_tat_r;
  assign out_waiting_time    = out_wt_r;
  assign out_last_result     = out_last_r;

endmodule

/* rtl/nonpreemptive_schedule_calculator_core.sv */
// Non-preemptive schedule calculator (first come first served, shortest job first, priority).
// Records go in through a queue-style push port, one per cycle while in_full is low, and are
// buffered in a short queue while the scheduler works. The record marked last starts the schedule
// over the stored batch of n records. Each selection round reads the stored records one per cycle
// through a single registered read port and ends in the pick state; a batch needs n picking
// rounds plus at most n idle jumps to the next arrival. Results then come out in index order,
// each through the read, subtract and output states, held in an output register until popped.
// The user must write policy_mode only while the block is idle; the block does not enforce it.
// Depends on snc_pkg, snc_front, snc_fifo and snc_sched.
module nonpreemptive_schedule_calculator_core #(
  parameter int unsigned MAX_PROCESSES = 8,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [snc_pkg::MODE_W-1:0]   cfg_policy_mode,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [snc_pkg::ARR_W-1:0]    in_arrival_time,
  input  logic [snc_pkg::BUR_W-1:0]    in_burst_time,
  input  logic [snc_pkg::PRI_W-1:0]    in_priority_level,
  input  logic                         in_last_process,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [snc_pkg::IDX_W-1:0]    out_process_index,
  output logic [snc_pkg::TIME_W-1:0]   out_completion_time,
  output logic [snc_pkg::TIME_W-1:0]   out_turnaround_time,
  output logic [snc_pkg::TIME_W-1:0]   out_waiting_time,
  output logic                         out_last_result
);

  logic [snc_pkg::MODE_W-1:0] mode_r;
  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_empty;
  snc_pkg::snc_rec_t          q_wr_rec;
  snc_pkg::snc_rec_t          q_rd_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= snc_pkg::MODE_FCFS;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_policy_mode;
    end
  end

  snc_front #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_arrival_time  (in_arrival_time),
    .in_burst_time    (in_burst_time),
    .in_priority_level(in_priority_level),
    .in_last_process  (in_last_process),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_rec            (q_wr_rec)
  );

  snc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_rec(q_wr_rec),
    .full  (q_full),
    .pop   (q_pop),
    .rd_rec(q_rd_rec),
    .empty (q_empty)
  );

  snc_sched #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_sched (
    .clk                (clk),
    .rst_n              (rst_n),
    .mode               (mode_r),
    .q_rec              (q_rd_rec),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_process_index  (out_process_index),
    .out_completion_time(out_completion_time),
    .out_turnaround_time(out_turnaround_time),
    .out_waiting_time   (out_waiting_time),
    .out_last_result    (out_last_result)
  );

endmodule

/* rtl/snc_checker.sv */
// Port-level checks for the schedule calculator, bound to the top level.
// Depends on snc_pkg and nonpreemptive_schedule_calculator_core.
module snc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [snc_pkg::IDX_W-1:0]    out_process_index,
  input logic [snc_pkg::TIME_W-1:0]   out_completion_time,
  input logic [snc_pkg::TIME_W-1:0]   out_turnaround_time,
  input logic [snc_pkg::TIME_W-1:0]   out_waiting_time,
  input logic                         out_last_result
);

  // No result may be shown right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");

  // A waiting result that is not popped keeps its beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_process_index)
      && $stable(out_completion_time) && $stable(out_last_result))
    else $error("waiting result changed");

  // Every process arrives before it completes.
  a_tat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_turnaround_time <= out_completion_time)
    else $error("turnaround exceeds completion time");

  // A process runs for its burst inside its turnaround.
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_waiting_time <= out_turnaround_time)
    else $error("waiting time exceeds turnaround");

endmodule

bind nonpreemptive_schedule_calculator_core snc_checker u_snc_checker (.*);
